// ----- rtl/core/pto_pkg.sv -----
// Shared types and constants for the pose trip odometer.
package pto_pkg;

    localparam int POS_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int SPEED_W  = 32;
    localparam int DIST_W   = 48;
    localparam int TIME_W   = 56;
    localparam int SEC_W    = 32;
    localparam int NSEC_W   = 30;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    localparam int DIFF_W   = POS_W + 1;
    localparam int ROOT_W   = DIFF_W;
    localparam int RAD_W    = 2 * DIFF_W;
    localparam int STAMP_W  = 62;
    localparam int DT_W     = STAMP_W;
    localparam int NUM_W    = 63;
    localparam int REM_W    = 64;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = SPEED_W;
    localparam int CNT_W      = 6;

    localparam logic [NSEC_W-1:0]  NS_PER_SEC   = NSEC_W'(1000000000);
    localparam logic [SPEED_W-1:0] THRESH_RESET = SPEED_W'((1 << FRAC_W) / 100);
    localparam logic [SPEED_W-1:0] SPEED_SAT    = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX     = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX     = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_DIST  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAX   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_START_MOVE  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_START_TOTAL = CFG_IDX_W'(4);

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SEC_W-1:0]        stamp_sec;
        logic [NSEC_W-1:0]       stamp_nsec;
    } t_in_item;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [DIST_W-1:0]  total_distance;
        logic [SPEED_W-1:0] peak_speed;
        logic [TIME_W-1:0]  moving_time;
        logic [TIME_W-1:0]  elapsed_time;
        logic               bad_interval;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic div_mode;
    } t_iter_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_stat;

endpackage

// ----- rtl/core/pose_trip_odometer.sv -----
// Trip odometer top level: sample sequencer, shared multiplier and trip totals.
// Each position sample goes from acceptance to result as follows: a
// 33x33 multiplier forms the timestamp in ns and the squared offsets, then one
// shift-subtract unit runs 33 square-root steps and 32 quotient steps for the
// speed. The first sample and a zero or negative time step skip the quotient
// steps; a saturated speed skips them too. Input stall stays high from
// acceptance until the result is loaded into the output register, so a new
// sample is accepted only once the previous result is loaded; a finished
// result may wait there while the next sample is accepted.
// Configuration is always ready; writing a start register also loads its
// running total.
module pose_trip_odometer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pto_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pto_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pto_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pto_pkg::CFG_W-1:0]         i_cfg_data
);
    import pto_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MT, S_MX, S_MY, S_ADD, S_SQS, S_SQRT,
        S_MN, S_CHK, S_DIV, S_DONE
    } t_state;

    t_state                   r_state;
    t_in_item                 r_cur;
    logic                     r_have_prev;
    logic signed [POS_W-1:0]  r_prev_x;
    logic signed [POS_W-1:0]  r_prev_y;
    logic [STAMP_W-1:0]       r_prev_t;
    logic [STAMP_W-1:0]       r_t_cur;
    logic [DIFF_W-1:0]        r_ax;
    logic [DIFF_W-1:0]        r_ay;
    logic [RAD_W-1:0]         r_prod;
    logic [RAD_W-1:0]         r_rad;
    logic [DT_W:0]            r_dt;
    logic                     r_bad;
    logic [ROOT_W-1:0]        r_step;
    logic [SPEED_W-1:0]       r_speed;
    logic [SPEED_W-1:0]       r_thresh;
    logic [DIST_W-1:0]        r_dist;
    logic [SPEED_W-1:0]       r_max;
    logic [TIME_W-1:0]        r_moving;
    logic [TIME_W-1:0]        r_total;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic [DIFF_W-1:0]        mul_a;
    logic [DIFF_W-1:0]        mul_b;
    logic [RAD_W-1:0]         mul_p;
    logic [DIFF_W-1:0]        dx;
    logic [DIFF_W-1:0]        dy;
    logic                     spd_sat;
    logic                     out_free;
    logic                     dt_ok;
    logic [DIST_W:0]          dist_sum;
    logic [STAMP_W:0]         total_sum;
    logic [STAMP_W:0]         moving_sum;
    logic [DIST_W-1:0]        n_dist;
    logic [TIME_W-1:0]        n_total;
    logic [TIME_W-1:0]        n_moving;
    logic [SPEED_W-1:0]       n_max;

    t_iter_ctrl               iter_ctrl;
    t_iter_stat               iter_stat;
    logic [RAD_W-1:0]         iter_opnd;
    logic [ROOT_W-1:0]        iter_root;
    logic [SPEED_W-1:0]       iter_quot;

    pto_iter_unit u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (iter_ctrl),
        .i_opnd  (iter_opnd),
        .i_den   (r_dt[DT_W-1:0]),
        .o_stat  (iter_stat),
        .o_root  (iter_root),
        .o_quot  (iter_quot)
    );

    always_comb begin
        case (r_state)
            S_MT: begin
                mul_a = DIFF_W'(r_cur.stamp_sec);
                mul_b = DIFF_W'(NS_PER_SEC);
            end
            S_MX: begin
                mul_a = r_ax;
                mul_b = r_ax;
            end
            S_MY: begin
                mul_a = r_ay;
                mul_b = r_ay;
            end
            S_MN: begin
                mul_a = r_step;
                mul_b = DIFF_W'(NS_PER_SEC);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dx = {r_cur.pos_x[POS_W-1], r_cur.pos_x} - {r_prev_x[POS_W-1], r_prev_x};
    assign dy = {r_cur.pos_y[POS_W-1], r_cur.pos_y} - {r_prev_y[POS_W-1], r_prev_y};

    assign spd_sat = DT_W'(r_prod[NUM_W-1:SPEED_W]) >= r_dt[DT_W-1:0];

    assign iter_ctrl.start    = (r_state == S_SQS) || (r_state == S_CHK && !spd_sat);
    assign iter_ctrl.div_mode = (r_state == S_CHK);
    assign iter_opnd          = (r_state == S_CHK) ? RAD_W'(r_prod[NUM_W-1:0]) : r_rad;

    assign out_free = !r_out_valid || !i_out_stall;
    assign dt_ok    = r_have_prev && !r_bad;

    always_comb begin
        dist_sum   = {1'b0, r_dist} + (DIST_W+1)'(r_have_prev ? r_step : '0);
        total_sum  = (STAMP_W+1)'(r_total) + (STAMP_W+1)'(r_dt[DT_W-1:0]);
        moving_sum = (STAMP_W+1)'(r_moving) + (STAMP_W+1)'(r_dt[DT_W-1:0]);
        n_dist     = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
        n_total    = r_total;
        n_moving   = r_moving;
        n_max      = r_max;
        if (dt_ok) begin
            n_total = (total_sum > (STAMP_W+1)'(TIME_MAX)) ? TIME_MAX
                                                           : total_sum[TIME_W-1:0];
            if (r_speed > r_thresh) begin
                n_moving = (moving_sum > (STAMP_W+1)'(TIME_MAX)) ? TIME_MAX
                                                                 : moving_sum[TIME_W-1:0];
            end
            if (r_speed > r_max) begin
                n_max = r_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_t    <= '0;
            r_thresh    <= THRESH_RESET;
            r_dist      <= '0;
            r_max       <= '0;
            r_moving    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cur   <= i_in_data;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_ax    <= dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
                    r_ay    <= dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
                    r_state <= S_MT;
                end
                S_MT: begin
                    r_prod  <= mul_p;
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_t_cur <= r_prod[STAMP_W-1:0] + STAMP_W'(r_cur.stamp_nsec);
                    r_prod  <= mul_p;
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_rad   <= r_prod;
                    r_prod  <= mul_p;
                    r_dt    <= {1'b0, r_t_cur} - {1'b0, r_prev_t};
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_rad   <= r_rad + r_prod;
                    r_bad   <= r_dt[DT_W] || (r_dt == '0);
                    r_state <= S_SQS;
                end
                S_SQS: begin
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (iter_stat.done) begin
                        r_step  <= iter_root;
                        r_state <= S_MN;
                    end
                end
                S_MN: begin
                    r_prod  <= mul_p;
                    r_speed <= '0;
                    r_state <= dt_ok ? S_CHK : S_DONE;
                end
                S_CHK: begin
                    if (spd_sat) begin
                        r_speed <= SPEED_SAT;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (iter_stat.done) begin
                        r_speed <= iter_quot;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_dist               <= n_dist;
                        r_total              <= n_total;
                        r_moving             <= n_moving;
                        r_max                <= n_max;
                        r_out.speed          <= r_speed;
                        r_out.total_distance <= n_dist;
                        r_out.peak_speed     <= n_max;
                        r_out.moving_time    <= n_moving;
                        r_out.elapsed_time   <= n_total;
                        r_out.bad_interval   <= r_have_prev && r_bad;
                        r_out_valid          <= 1'b1;
                        r_have_prev          <= 1'b1;
                        r_prev_x             <= r_cur.pos_x;
                        r_prev_y             <= r_cur.pos_y;
                        r_prev_t             <= r_t_cur;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_THRESHOLD:   r_thresh <= i_cfg_data[SPEED_W-1:0];
                    CFG_START_DIST:  r_dist   <= i_cfg_data[DIST_W-1:0];
                    CFG_START_MAX:   r_max    <= i_cfg_data[SPEED_W-1:0];
                    CFG_START_MOVE:  r_moving <= i_cfg_data[TIME_W-1:0];
                    CFG_START_TOTAL: r_total  <= i_cfg_data[TIME_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_bad_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_interval) |-> (o_out_data.speed == '0))
        else $error("bad interval result carries nonzero speed");

    a_peak_covers_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.peak_speed >= o_out_data.speed))
        else $error("peak speed below current speed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer did not start on accepted transaction");

    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !iter_stat.busy)
        else $error("shift-subtract unit busy while sequencer idle");

endmodule

// ----- rtl/core/pto_iter_unit.sv -----
// Shared shift-subtract unit: square root or long division, one digit per cycle.
module pto_iter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pto_pkg::t_iter_ctrl            i_ctrl,
    input  logic [pto_pkg::RAD_W-1:0]      i_opnd,
    input  logic [pto_pkg::DT_W-1:0]       i_den,
    output pto_pkg::t_iter_stat            o_stat,
    output logic [pto_pkg::ROOT_W-1:0]     o_root,
    output logic [pto_pkg::SPEED_W-1:0]    o_quot
);
    import pto_pkg::*;

    logic [RAD_W-1:0]  r_work;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_res;
    logic [DT_W-1:0]   r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              r_div;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              take;

    always_comb begin
        if (r_div) begin
            rem_sh = {r_rem[REM_W-2:0], r_work[RAD_W-1]};
            trial  = REM_W'(r_den);
        end else begin
            rem_sh = {r_rem[REM_W-3:0], r_work[RAD_W-1:RAD_W-2]};
            trial  = REM_W'({r_res, 2'b01});
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        take = !diff[REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_div  <= i_ctrl.div_mode;
                r_res  <= '0;
                r_den  <= i_den;
                if (i_ctrl.div_mode) begin
                    r_rem  <= REM_W'(i_opnd[NUM_W-1:SPEED_W]);
                    r_work <= {i_opnd[SPEED_W-1:0], (RAD_W-SPEED_W)'(0)};
                    r_cnt  <= CNT_W'(DIV_STEPS);
                end else begin
                    r_rem  <= '0;
                    r_work <= i_opnd;
                    r_cnt  <= CNT_W'(SQRT_STEPS);
                end
            end else if (r_busy) begin
                r_rem  <= take ? diff[REM_W-1:0] : rem_sh;
                r_res  <= {r_res[ROOT_W-2:0], take};
                r_work <= r_div ? {r_work[RAD_W-2:0], 1'b0} : {r_work[RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_res;
    assign o_quot      = r_res[SPEED_W-1:0];

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the pose trip odometer: directed, random and back-pressure traffic.
module testbench;
    import pto_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    logic                 have_fix = 1'b0;
    t_in_item             prev_fix = '0;
    logic [DIST_W-1:0]    trip_distance = '0;
    logic [SPEED_W-1:0]   trip_peak = '0;
    logic [SPEED_W-1:0]   moving_threshold = THRESH_RESET;
    logic [TIME_W-1:0]    trip_moving = '0;
    logic [TIME_W-1:0]    trip_elapsed = '0;

    t_out_item            pending_trips[$];
    t_in_item             walker = '0;
    int                   in_idle_pct = 0;
    int                   out_idle_pct = 0;
    int                   hold_cycles = 0;
    int                   mismatch_count = 0;
    int                   result_count = 0;
    int                   cycle_count;

    pose_trip_odometer uut (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .o_in_stall,
        .i_in_data,
        .o_out_valid,
        .i_out_stall,
        .o_out_data,
        .i_cfg_valid,
        .o_cfg_ready,
        .i_cfg_index,
        .i_cfg_data
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] acc,
                                                   input longint span_ns);
        logic [63:0] sum;
        sum = 64'(acc) + 64'(span_ns);
        return (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic t_out_item advance_trip(input t_in_item fix);
        t_out_item    trip;
        longint       dx;
        longint       dy;
        longint       dt;
        logic [67:0]  ax;
        logic [67:0]  ay;
        logic [67:0]  radicand;
        logic [67:0]  seg_len;
        logic [67:0]  trial;
        logic [67:0]  dist_sum;
        logic [127:0] scaled;
        logic [127:0] quotient;
        trip = '0;
        if (have_fix) begin
            dx = longint'($signed(fix.pos_x)) - longint'($signed(prev_fix.pos_x));
            dy = longint'($signed(fix.pos_y)) - longint'($signed(prev_fix.pos_y));
            ax = 68'((dx < 0) ? -dx : dx);
            ay = 68'((dy < 0) ? -dy : dy);
            radicand = ax * ax + ay * ay;
            seg_len = '0;
            for (int b = 33; b >= 0; b--) begin
                trial = seg_len | (68'd1 << b);
                if (trial * trial <= radicand)
                    seg_len = trial;
            end
            dist_sum = seg_len + 68'(trip_distance);
            trip_distance = (dist_sum > DIST_MAX) ? DIST_MAX : dist_sum[DIST_W-1:0];
            dt = (longint'(fix.stamp_sec) - longint'(prev_fix.stamp_sec)) * longint'(NS_PER_SEC)
                 + longint'(fix.stamp_nsec) - longint'(prev_fix.stamp_nsec);
            if (dt <= 0) begin
                trip.bad_interval = 1'b1;
            end else begin
                scaled = 128'(seg_len) * 128'(NS_PER_SEC);
                quotient = scaled / 128'(dt);
                trip.speed = (quotient > SPEED_SAT) ? SPEED_SAT : quotient[SPEED_W-1:0];
                trip_elapsed = sat_time(trip_elapsed, dt);
                if (trip.speed > moving_threshold)
                    trip_moving = sat_time(trip_moving, dt);
                if (trip.speed > trip_peak)
                    trip_peak = trip.speed;
            end
        end
        have_fix = 1'b1;
        prev_fix = fix;
        trip.total_distance = trip_distance;
        trip.peak_speed = trip_peak;
        trip.moving_time = trip_moving;
        trip.elapsed_time = trip_elapsed;
        return trip;
    endfunction

    function automatic t_in_item make_fix(input longint x, input longint y,
                                          input longint sec, input longint nsec);
        t_in_item fix;
        fix.pos_x = POS_W'(x);
        fix.pos_y = POS_W'(y);
        fix.stamp_sec = SEC_W'(sec);
        fix.stamp_nsec = NSEC_W'(nsec);
        return fix;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 200)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     result_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_THRESHOLD:   moving_threshold = value[SPEED_W-1:0];
            CFG_START_DIST:  trip_distance = value[DIST_W-1:0];
            CFG_START_MAX:   trip_peak = value[SPEED_W-1:0];
            CFG_START_MOVE:  trip_moving = value[TIME_W-1:0];
            CFG_START_TOTAL: trip_elapsed = value[TIME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_fix(input t_in_item fix);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= fix;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_trips.push_back(advance_trip(fix));
        walker = fix;
    endtask

    task automatic wait_for_results;
        while (pending_trips.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_fix;
        t_in_item    fix;
        longint      span;
        longint      now_ns;
        int unsigned pick;
        pick = $urandom_range(99);
        fix = walker;
        now_ns = longint'(walker.stamp_sec) * longint'(NS_PER_SEC) + longint'(walker.stamp_nsec);
        if (pick < 75) begin
            case ($urandom_range(2))
                0:       span = 800;
                1:       span = 1 << 18;
                default: span = 1 << 26;
            endcase
            fix.pos_x = walker.pos_x + POS_W'(longint'($urandom_range(0, 2 * span)) - span);
            fix.pos_y = walker.pos_y + POS_W'(longint'($urandom_range(0, 2 * span)) - span);
            if ($urandom_range(3) == 0)
                now_ns += longint'($urandom_range(1, 5000));
            else
                now_ns += longint'($urandom_range(1000000, 250000000));
        end else if (pick < 85) begin
            fix.pos_y = walker.pos_y + POS_W'(longint'($urandom_range(0, 2000)) - 1000);
            if ($urandom_range(1) == 0)
                now_ns -= longint'($urandom_range(1, 2000000000));
            if (now_ns < 0)
                now_ns = 0;
        end else if (pick < 93) begin
            fix = {$urandom, $urandom, $urandom, NSEC_W'($urandom)};
        end else begin
            fix.pos_x = $urandom;
            fix.pos_y = $urandom;
            now_ns += longint'($urandom_range(1, 100));
        end
        if (pick < 85 || pick >= 93) begin
            fix.stamp_sec = SEC_W'(now_ns / longint'(NS_PER_SEC));
            fix.stamp_nsec = NSEC_W'(now_ns % longint'(NS_PER_SEC));
        end
        send_fix(fix);
    endtask

    task automatic test_first_samples;
        send_fix(make_fix(0, 0, 0, 0));
        send_fix(make_fix(655, 0, 1, 0));
        send_fix(make_fix(1311, 0, 2, 0));
        send_fix(make_fix(1311, 100, 2, 0));
        send_fix(make_fix(1311, 100, 1, 999999999));
        i_in_valid <= 1'b0;
        wait_for_results;
    endtask

    task automatic test_field_extremes;
        send_fix(make_fix(32'h8000_0000, 32'h8000_0000, 1, (1 << NSEC_W) - 1));
        send_fix(make_fix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 2, 73741824));
        send_fix(make_fix(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 999999999));
        send_fix(make_fix(0, 0, 0, 0));
        send_fix(make_fix(0, 0, 0, 0));
        send_fix(make_fix(0, 0, 0, 1));
        i_in_valid <= 1'b0;
        wait_for_results;
    endtask

    task automatic test_total_saturation;
        write_register(CFG_THRESHOLD, {$urandom, 32'd0});
        write_register(CFG_START_DIST, {16'($urandom), DIST_MAX - 48'd5});
        write_register(CFG_START_MAX, {$urandom, 32'd0});
        write_register(CFG_START_MOVE, {8'($urandom), TIME_MAX - 56'd10});
        write_register(CFG_START_TOTAL, {8'($urandom), TIME_MAX - 56'd10});
        for (int k = CFG_START_TOTAL + 1; k < 2 ** CFG_IDX_W; k++)
            write_register(CFG_IDX_W'(k), {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
        send_fix(make_fix(100, 0, 0, 11));
        send_fix(make_fix(300, 0, 0, 31));
        send_fix(make_fix(300, 1, 0, 41));
        i_in_valid <= 1'b0;
        wait_for_results;
        write_register(CFG_THRESHOLD, CFG_W'(SPEED_SAT));
        write_register(CFG_START_MAX, CFG_W'(SPEED_SAT));
        write_register(CFG_START_DIST, '0);
        write_register(CFG_START_MOVE, '0);
        write_register(CFG_START_TOTAL, '0);
        i_cfg_valid <= 1'b0;
        send_fix(make_fix(1300, 1, 0, 42));
        send_fix(make_fix(1301, 1, 1, 42));
        i_in_valid <= 1'b0;
        wait_for_results;
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        write_register(CFG_THRESHOLD,
                       {$urandom, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 22)});
        write_register(CFG_START_DIST, {$urandom, $urandom});
        write_register(CFG_START_MAX, {$urandom, $urandom_range(0, 1 << 24)});
        write_register(CFG_START_MOVE, {$urandom, $urandom});
        write_register(CFG_START_TOTAL, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
        in_idle_pct = send_pct;
        out_idle_pct = recv_pct;
        repeat (count) send_random_fix;
        i_in_valid <= 1'b0;
        wait_for_results;
    endtask

    task automatic test_output_backpressure;
        in_idle_pct = 0;
        out_idle_pct = 0;
        hold_cycles = 400;
        repeat (6) send_random_fix;
        i_in_valid <= 1'b0;
        wait_for_results;
        repeat (6) send_random_fix;
        i_in_valid <= 1'b0;
        wait_for_results;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            result_count++;
            if (pending_trips.size() == 0) begin
                report_mismatch("unexpected result", '0, '0);
            end else begin
                want = pending_trips.pop_front();
                if (o_out_data.speed !== want.speed)
                    report_mismatch("speed", 64'(o_out_data.speed), 64'(want.speed));
                if (o_out_data.total_distance !== want.total_distance)
                    report_mismatch("total_distance", 64'(o_out_data.total_distance),
                                    64'(want.total_distance));
                if (o_out_data.peak_speed !== want.peak_speed)
                    report_mismatch("peak_speed", 64'(o_out_data.peak_speed),
                                    64'(want.peak_speed));
                if (o_out_data.moving_time !== want.moving_time)
                    report_mismatch("moving_time", 64'(o_out_data.moving_time),
                                    64'(want.moving_time));
                if (o_out_data.elapsed_time !== want.elapsed_time)
                    report_mismatch("elapsed_time", 64'(o_out_data.elapsed_time),
                                    64'(want.elapsed_time));
                if (o_out_data.bad_interval !== want.bad_interval)
                    report_mismatch("bad_interval", 64'(o_out_data.bad_interval),
                                    64'(want.bad_interval));
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_samples;
        test_field_extremes;
        test_total_saturation;
        test_random_traffic(31, 77, 125);
        test_random_traffic(77, 31, 125);
        test_random_traffic(0, 0, 125);
        test_output_backpressure;
        wait_for_results;
        repeat (100) @(posedge i_clk);
        if (pending_trips.size() != 0)
            report_mismatch("results missing", 64'(pending_trips.size()), '0);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
